@@ hdl/sorted_key_table_defines.svh @@
// ----------------------------------------------------------------------------
// sorted_key_table_defines.svh
// Assertion macros shared by the sorted key table RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SKT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg
// Shared sizes, codes and types of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  // Table size and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int DATA_W   = 16;
  localparam int CMD_W    = 2;
  localparam int ST_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  // Command code with no operation behind it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One table entry
  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] branch;
    logic [DATA_W-1:0] payload;
  } entry_t;

  // Per-cycle controls broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

@@ hdl/sorted_key_table.sv @@
// Timing: a request taken into the request registers is executed while busy
// is high and its result is registered with done high; the result is shown for
// one cycle only. A new request is not taken while busy is high; busy is high
// in the cycle where the cell chain compares and shifts all slots at once.
// Reset: synchronous rst empties the table (entry_count 0); slot contents
// are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
// sorted_key_table
// Bounded table kept in ascending key order by a chain of compare cells.
// ----------------------------------------------------------------------------
module sorted_key_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [skt_pkg::CMD_W-1:0]  command,
  input  logic [skt_pkg::DATA_W-1:0] average_age,
  input  logic [skt_pkg::DATA_W-1:0] branch_id,
  input  logic [skt_pkg::DATA_W-1:0] payload_ref,
  input  logic [skt_pkg::POS_W-1:0]  position,
  output logic                      done,
  output logic [skt_pkg::ST_W-1:0]   status,
  output logic [skt_pkg::DATA_W-1:0] out_payload_ref,
  output logic [skt_pkg::DATA_W-1:0] out_branch_id,
  output logic [skt_pkg::DATA_W-1:0] out_average_age,
  output logic [skt_pkg::CNT_W-1:0]  entry_count
);
  import skt_pkg::*;

  `include "sorted_key_table_defines.svh"

  // Request registers
  logic              req_valid;
  cmd_t              req_cmd;
  entry_t            req_entry;
  logic [POS_W-1:0]  req_pos;

  // Table state
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  // Result registers
  logic              res_valid;
  status_t           res_status;
  entry_t            res_entry;

  // Decode
  logic              full;
  logic              pos_ok;
  logic [IDX_W-1:0]  slot;
  logic              do_insert;
  logic              do_remove;
  status_t           status_next;
  entry_t            data_next;
  cell_ctrl_t        ctrl;

  // Cell chain wiring
  entry_t            cell_entry [CAPACITY];
  logic              cell_after [CAPACITY];

  // Accept a request and hold it for the execute cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !req_valid) begin
      req_cmd           <= cmd_t'(command);
      req_entry.key     <= average_age;
      req_entry.branch  <= branch_id;
      req_entry.payload <= payload_ref;
      req_pos           <= position;
    end
  end

  assign busy = req_valid;

  // Decode the held request
  assign full   = (count == CNT_W'(CAPACITY));
  assign pos_ok = (req_pos != '0) &&
                  (CMP_W'(req_pos) <= CMP_W'(count));
  assign slot   = IDX_W'(req_pos - POS_W'(1));

  always_comb begin
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    status_next = ST_RANGE;
    data_next   = '0;
    count_next  = count;
    case (req_cmd)
      CMD_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          do_insert   = req_valid;
          status_next = ST_OK;
          count_next  = count + CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (pos_ok) begin
          status_next = ST_OK;
          data_next   = cell_entry[slot];
        end
      end
      CMD_REMOVE: begin
        if (pos_ok) begin
          do_remove   = req_valid;
          status_next = ST_OK;
          data_next   = cell_entry[slot];
          count_next  = count - CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_RANGE;
      end
    endcase
  end

  assign ctrl.insert = do_insert;
  assign ctrl.remove = do_remove;

  // Build the chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occ;
    logic   rem_here;
    logic   l_after;
    entry_t l_entry;
    entry_t r_entry;

    assign occ      = (CNT_W'(i) < count);
    assign rem_here = (IDX_W'(i) >= slot);

    if (i == 0) begin : g_head
      assign l_after = 1'b0;
      assign l_entry = req_entry;
    end else begin : g_body
      assign l_after = cell_after[i-1];
      assign l_entry = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_entry = cell_entry[i];
    end else begin : g_inner
      assign r_entry = cell_entry[i+1];
    end

    skt_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occ),
      .remove_here (rem_here),
      .new_entry   (req_entry),
      .left_after  (l_after),
      .left_entry  (l_entry),
      .right_entry (r_entry),
      .after       (cell_after[i]),
      .entry       (cell_entry[i])
    );
  end

  // Advance the entry count and strobe the result
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= req_valid;
      if (req_valid) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      res_status <= status_next;
      res_entry  <= data_next;
    end
  end

  assign done            = res_valid;
  assign status          = res_status;
  assign out_payload_ref = res_entry.payload;
  assign out_branch_id   = res_entry.branch;
  assign out_average_age = res_entry.key;
  assign entry_count     = count;

  // Checks
  `SKT_ASSERT_NEXT(a_exec_then_done, clk, rst, req_valid, res_valid, "execute without result")
  `SKT_ASSERT_SAME(a_done_not_busy, clk, rst, res_valid, !req_valid, "busy held past one cycle")
  `SKT_ASSERT_SAME(a_full_count, clk, rst, res_valid && (res_status == ST_FULL), count == CNT_W'(CAPACITY), "full reported below capacity")
  `SKT_ASSERT_NEXT(a_insert_grows, clk, rst, do_insert, count == $past(count) + CNT_W'(1), "insert did not grow count")
  `SKT_ASSERT_SAME(a_no_overflow, clk, rst, 1'b1, count <= CNT_W'(CAPACITY), "count beyond capacity")

endmodule

@@ hdl/skt_cell.sv @@
// ----------------------------------------------------------------------------
// skt_cell
// One slot of the sorted chain: holds an entry, compares it with the
// incoming key and shifts right on insert or left on remove.
// ----------------------------------------------------------------------------
module skt_cell (
  input  logic                clk,
  input  skt_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  logic                remove_here,
  input  skt_pkg::entry_t     new_entry,
  input  logic                left_after,
  input  skt_pkg::entry_t     left_entry,
  input  skt_pkg::entry_t     right_entry,
  output logic                after,
  output skt_pkg::entry_t     entry
);
  import skt_pkg::*;

  // Slot lies behind the insert point: empty, or key strictly greater
  assign after = !occupied || (entry.key > new_entry.key);

  // Shift right on insert, take the new request at the insert point,
  // shift left on remove from the removed slot onward
  always_ff @(posedge clk) begin
    if (ctrl.insert && after) begin
      entry <= left_after ? left_entry : new_entry;
    end else if (ctrl.remove && remove_here) begin
      entry <= right_entry;
    end
  end

endmodule

@@ verif/sorted_key_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_checker
// Watches the request and result ports of the sorted key table, keeps its
// own copy of the sorted entries, predicts one result per accepted request
// and compares every strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_key_table_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [skt_pkg::CMD_W-1:0]  command,
  input  logic [skt_pkg::DATA_W-1:0] average_age,
  input  logic [skt_pkg::DATA_W-1:0] branch_id,
  input  logic [skt_pkg::DATA_W-1:0] payload_ref,
  input  logic [skt_pkg::POS_W-1:0]  position,
  input  logic                      done,
  input  logic [skt_pkg::ST_W-1:0]   status,
  input  logic [skt_pkg::DATA_W-1:0] out_payload_ref,
  input  logic [skt_pkg::DATA_W-1:0] out_branch_id,
  input  logic [skt_pkg::DATA_W-1:0] out_average_age,
  input  logic [skt_pkg::CNT_W-1:0]  entry_count,
  output int                        fail_count,
  output int                        open_count
);
  import skt_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] payload;
    logic [DATA_W-1:0] branch;
    logic [DATA_W-1:0] key;
    logic [CNT_W-1:0]  count;
  } outcome_t;

  entry_t   rows [CAPACITY];
  int       row_count;
  outcome_t expected_q [$];
  int       mismatch_total;

  assign fail_count = mismatch_total;

  task automatic flag(string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    mismatch_total++;
  endtask

  // Apply one request to the shadow table and return the result it causes
  function automatic outcome_t apply_request(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] key,
                                             logic [DATA_W-1:0] br, logic [DATA_W-1:0] pl,
                                             logic [POS_W-1:0] pos);
    outcome_t res;
    int       slot;
    res = '0;
    if (cmd == CMD_INSERT) begin
      if (row_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        // land after every key less than or equal, so ties keep arrival order
        slot = 0;
        while (slot < row_count && rows[slot].key <= key) slot++;
        for (int i = row_count; i > slot; i--) rows[i] = rows[i-1];
        rows[slot] = '{key: key, branch: br, payload: pl};
        row_count++;
        res.status = ST_OK;
      end
    end else if (cmd == CMD_UNUSED || pos == 0 || pos > row_count) begin
      res.status = ST_RANGE;
    end else begin
      slot        = pos - 1;
      res.status  = ST_OK;
      res.payload = rows[slot].payload;
      res.branch  = rows[slot].branch;
      res.key     = rows[slot].key;
      if (cmd == CMD_REMOVE) begin
        // close the gap
        for (int i = slot; i + 1 < row_count; i++) rows[i] = rows[i+1];
        row_count--;
      end
    end
    res.count = row_count[CNT_W-1:0];
    return res;
  endfunction

  // Predict on each accepted request, compare on each result strobe
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      row_count = 0;
      expected_q.delete();
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          flag("result strobe with no request outstanding");
        end else begin
          want = expected_q.pop_front();
          if (status !== want.status)
            flag($sformatf("status got %0d want %0d", status, want.status));
          if (out_payload_ref !== want.payload)
            flag($sformatf("out_payload_ref got %h want %h", out_payload_ref, want.payload));
          if (out_branch_id !== want.branch)
            flag($sformatf("out_branch_id got %h want %h", out_branch_id, want.branch));
          if (out_average_age !== want.key)
            flag($sformatf("out_average_age got %h want %h", out_average_age, want.key));
          if (entry_count !== want.count)
            flag($sformatf("entry_count got %0d want %0d", entry_count, want.count));
        end
      end
      if (start && !busy)
        expected_q.push_back(apply_request(command, average_age, branch_id,
                                           payload_ref, position));
    end
    open_count <= expected_q.size();
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random insert, read, remove and unused-code requests into the
// sorted key table, with sender gaps of varying density, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
  import skt_pkg::*;

  localparam int RANDOM_ITEMS = 550;

  logic              clk             = 1'b0;
  logic              rst             = 1'b1;
  logic              start           = 1'b0;
  logic [CMD_W-1:0]  command         = '0;
  logic [DATA_W-1:0] average_age     = '0;
  logic [DATA_W-1:0] branch_id       = '0;
  logic [DATA_W-1:0] payload_ref     = '0;
  logic [POS_W-1:0]  position        = '0;
  logic              busy;
  logic              done;
  logic [ST_W-1:0]   status;
  logic [DATA_W-1:0] out_payload_ref;
  logic [DATA_W-1:0] out_branch_id;
  logic [DATA_W-1:0] out_average_age;
  logic [CNT_W-1:0]  entry_count;
  int                fail_count;
  int                open_count;

  // Stimulus-side view of the fill level, used to aim positions, fill the table and tally range errors
  int shadow_count = 0;
  int gap_pct      = 7;
  int n_insert     = 0;
  int n_read       = 0;
  int n_remove     = 0;
  int n_unused     = 0;
  int n_full_hits  = 0;
  int n_range      = 0;

  always #2 clk = ~clk;

  sorted_key_table dut (
    .clk, .rst, .start, .busy, .command, .average_age, .branch_id, .payload_ref,
    .position, .done, .status, .out_payload_ref, .out_branch_id, .out_average_age,
    .entry_count
  );

  sorted_key_table_checker u_checker (
    .clk, .rst, .start, .busy, .command, .average_age, .branch_id, .payload_ref,
    .position, .done, .status, .out_payload_ref, .out_branch_id, .out_average_age,
    .entry_count, .fail_count, .open_count
  );

  // Hold off, then present one request and wait for it to be taken
  task automatic issue(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] key,
                       logic [DATA_W-1:0] br, logic [DATA_W-1:0] pl,
                       logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    command     <= cmd;
    average_age <= key;
    branch_id   <= br;
    payload_ref <= pl;
    position    <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    // tally what the request did to the fill level
    case (cmd)
      CMD_INSERT: begin
        n_insert++;
        if (shadow_count < CAPACITY) shadow_count++;
        else n_full_hits++;
      end
      CMD_READ, CMD_REMOVE: begin
        if (cmd == CMD_READ) n_read++;
        else n_remove++;
        if (pos == 0 || pos > shadow_count) n_range++;
        else if (cmd == CMD_REMOVE) shadow_count--;
      end
      default: n_unused++;
    endcase
  endtask

  // Random request, biased toward growing or shrinking the table
  task automatic random_request(bit grow);
    int               r;
    int               ins_pct;
    logic [CMD_W-1:0] cmd;
    logic [DATA_W-1:0] key;
    logic [POS_W-1:0] pos;
    ins_pct = grow ? 65 : 25;
    r = $urandom_range(0, 99);
    // cluster half the keys on a few values to exercise ties
    key = $urandom_range(0, 1) ? DATA_W'($urandom_range(0, 3) << 8) : DATA_W'($urandom);
    if (r < 3) cmd = CMD_UNUSED;
    else if (r < 3 + ins_pct) cmd = CMD_INSERT;
    else cmd = $urandom_range(0, 1) ? CMD_READ : CMD_REMOVE;
    if ($urandom_range(0, 99) < 8 || shadow_count == 0) begin
      // out of range: zero, just beyond, or far beyond the fill level
      case ($urandom_range(0, 2))
        0:       pos = '0;
        1:       pos = POS_W'(shadow_count + 1);
        default: pos = POS_W'($urandom_range(shadow_count + 1, 31));
      endcase
    end else begin
      pos = POS_W'($urandom_range(1, shadow_count));
    end
    issue(cmd, key, DATA_W'($urandom), DATA_W'($urandom), pos);
  endtask

  // Run limit
  initial begin
    #500000;
    $display("Timed out waiting for results");
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, unused code, extreme keys and ties
    issue(CMD_READ,   16'h1234, 16'h0000, 16'h0000, 5'd1);
    issue(CMD_REMOVE, 16'h0000, 16'hFFFF, 16'hFFFF, 5'd1);
    issue(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31);
    issue(CMD_INSERT, 16'hFFFF, 16'hFFFF, 16'h0000, 5'd0);
    issue(CMD_INSERT, 16'h0000, 16'h0000, 16'hFFFF, 5'd31);
    issue(CMD_INSERT, 16'h8000, 16'hAAAA, 16'h5555, 5'd0);
    issue(CMD_INSERT, 16'h8000, 16'h5555, 16'hAAAA, 5'd0);
    issue(CMD_READ,   16'h0000, 16'h0000, 16'h0000, 5'd0);
    issue(CMD_READ,   16'h0000, 16'h0000, 16'h0000, 5'd31);
    issue(CMD_READ,   16'h0000, 16'h0000, 16'h0000, 5'd4);
    issue(CMD_READ,   16'h0000, 16'h0000, 16'h0000, 5'd5);
    issue(CMD_REMOVE, 16'h0000, 16'h0000, 16'h0000, 5'd2);
    issue(CMD_REMOVE, 16'h0000, 16'h0000, 16'h0000, 5'd1);
    // fill to capacity, then push one more into the full table
    while (shadow_count < CAPACITY)
      issue(CMD_INSERT, DATA_W'($urandom_range(0, 2) << 15), DATA_W'($urandom),
            DATA_W'($urandom), 5'd0);
    issue(CMD_INSERT, 16'h4000, 16'h1111, 16'h2222, 5'd0);
    issue(CMD_READ,   16'h0000, 16'h0000, 16'h0000, 5'd16);
    issue(CMD_REMOVE, 16'h0000, 16'h0000, 16'h0000, 5'd16);

    // Random: sparse gaps, dense gaps, then back to back
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) gap_pct = 50;
      else if (i == 2 * RANDOM_ITEMS / 3) gap_pct = 0;
      random_request(((i / 40) % 2) == 0);
    end
    start <= 1'b0;

    // Drain, then allow the pipeline to settle
    do @(posedge clk); while (open_count != 0);
    repeat (6) @(posedge clk);

    $display("Covered %0d inserts, %0d reads, %0d removes, %0d unused-code requests",
             n_insert, n_read, n_remove, n_unused);
    $display("Inserts into a full table: %0d, out-of-range reads/removes: %0d",
             n_full_hits, n_range);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/skt_pkg.sv
hdl/skt_cell.sv
hdl/sorted_key_table.sv
verif/sorted_key_table_checker.sv
verif/testbench.sv
